// ===== src/um32_instruction_executor_top_macros.svh =====
// Assertion macros for the UM32 instruction executor.
`ifndef UM32_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define UM32_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define UM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define UM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/um32_pkg.sv =====
// Shared types and constants for the UM32 instruction executor.
package um32_pkg;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int OPC_SHIFT = 28;
   localparam int LV_A_SHIFT = 25;
   localparam int A_SHIFT = 6;
   localparam int B_SHIFT = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      KIND_DONE = 4'd0, KIND_OUT = 4'd1, KIND_INREQ = 4'd2, KIND_LOAD = 4'd3,
      KIND_STORE = 4'd4, KIND_MAP = 4'd5, KIND_UNMAP = 4'd6, KIND_PROG = 4'd7,
      KIND_HALT = 4'd8, KIND_ERR = 4'd9
   } kind_type;

   typedef enum logic [3:0] {
      OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
      OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
      OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
      OP_PROG = 4'd12, OP_LV = 4'd13, OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      EX_IDLE, EX_MUL, EX_DIV, EX_WRITE, EX_RESULT
   } ex_state_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        is_resp;
      opcode_type  op;
      logic [REG_IDX_W-1:0] ra;
      logic [REG_IDX_W-1:0] rb;
      logic [REG_IDX_W-1:0] rc;
      logic [REG_IDX_W-1:0] lv_a;
      logic [24:0] imm;
      logic [31:0] resp;
   } item_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;
endpackage

// ===== src/um32_front.sv =====
// Front end: accepts items, decodes fields and queues them for execution.
module um32_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [31:0]       req_instr_word,
   input  logic [31:0]       req_response_data,
   output logic              q_valid,
   input  logic              q_pop,
   output um32_pkg::item_type q_item
);
   import um32_pkg::*;
   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0] cnt_ff, cnt_in;
   queue_ctl_type ctl;
   item_type dec;

   always_comb begin
      dec.is_resp = req_action;
      dec.op      = opcode_type'(req_instr_word[OPC_SHIFT +: 4]);
      dec.ra      = req_instr_word[A_SHIFT +: REG_IDX_W];
      dec.rb      = req_instr_word[B_SHIFT +: REG_IDX_W];
      dec.rc      = req_instr_word[0 +: REG_IDX_W];
      dec.lv_a    = req_instr_word[LV_A_SHIFT +: REG_IDX_W];
      dec.imm     = req_instr_word[24:0];
      dec.resp    = req_response_data;
   end

   assign ctl.full = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign ctl.push = req_valid && !ctl.full;
   assign req_stall = ctl.full;
   assign q_valid = (cnt_ff != '0);
   assign q_item = mem_ff[rd_ff];

   always_comb begin
      wr_in = ctl.push ? wr_ff + 1'b1 : wr_ff;
      rd_in = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(ctl.push) - (PW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (ctl.push) mem_ff[wr_ff] <= dec;
   end

`include "um32_instruction_executor_top_macros.svh"
   `UM_ASSERT_IMP(a_no_pop_empty, clock, reset, q_pop, q_valid, "pop from empty queue")
   `UM_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= (PW+1)'(QUEUE_DEPTH), "queue overfill")
   `UM_ASSERT_NXT(a_cnt_track, clock, reset, ctl.push && !q_pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "queue count slip")
endmodule

// ===== src/um32_divider.sv =====
// Radix-2 restoring divider, one quotient bit a cycle.
module um32_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [5:0] n_ff, n_in;
   logic busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff; busy_in = busy_ff;
      trial = {r_ff, q_ff[31]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == 6'd1) busy_in = 1'b0;
      end
   end

   assign done = busy_ff && (n_ff == 6'd1);
   assign quotient = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         n_ff <= n_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end
endmodule

// ===== src/um32_back.sv =====
// Back end: register file, program counter and instruction execution.
module um32_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  um32_pkg::item_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_kind,
   output logic [31:0]       rsp_segment_id,
   output logic [31:0]       rsp_offset_or_size,
   output logic [31:0]       rsp_data_value,
   output logic [31:0]       rsp_next_pc
);
   import um32_pkg::*;

   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] pc_ff, pc_in;
   logic waiting_ff, waiting_in, halted_ff, halted_in;
   logic [REG_IDX_W-1:0] pend_ff, pend_in;
   ex_state_type st_ff, st_in;
   item_type cur_ff, cur_in;
   logic [31:0] prod_ff, prod_in, wval_ff, wval_in;
   logic [REG_IDX_W-1:0] widx_ff, widx_in;
   logic out_v_ff, out_v_in;
   logic [3:0] kind_ff, kind_in;
   logic [31:0] seg_ff, seg_in, off_ff, off_in, dat_ff, dat_in;
   logic div_start, div_done;
   logic [31:0] div_q;
   logic [31:0] rb_v, rc_v, ra_v;

   assign ra_v = regs_ff[cur_ff.ra];
   assign rb_v = regs_ff[cur_ff.rb];
   assign rc_v = regs_ff[cur_ff.rc];

   um32_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(rb_v),
      .divisor(rc_v), .done(div_done), .quotient(div_q)
   );

   // output register frees once taken
   logic out_free;
   assign out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         EX_IDLE:   if (q_valid) st_in = EX_RESULT;
         EX_MUL:    st_in = EX_WRITE;
         EX_DIV:    if (div_done) st_in = EX_WRITE;
         EX_WRITE:  st_in = EX_IDLE;
         EX_RESULT: begin
            if (out_free) begin
               if (halted_ff || cur_ff.is_resp || waiting_ff) st_in = EX_IDLE;
               else if (cur_ff.op == OP_MUL) st_in = EX_MUL;
               else if (cur_ff.op == OP_DIV && rc_v != '0) st_in = EX_DIV;
               else if (cur_ff.op inside {OP_CMOV, OP_ADD, OP_NAND, OP_LV})
                  st_in = EX_WRITE;
               else st_in = EX_IDLE;
            end
         end
         default:   st_in = EX_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (st_ff == EX_IDLE) && q_valid;
      cur_in = q_pop ? q_item : cur_ff;
      div_start = 1'b0;
      pc_in = pc_ff; waiting_in = waiting_ff; halted_in = halted_ff; pend_in = pend_ff;
      prod_in = prod_ff; wval_in = wval_ff; widx_in = widx_ff;
      out_v_in = out_v_ff && rsp_stall;
      kind_in = kind_ff; seg_in = seg_ff; off_in = off_ff; dat_in = dat_ff;
      case (st_ff)
         EX_MUL: begin
            wval_in = prod_ff;
         end
         EX_DIV: begin
            wval_in = div_q;
         end
         EX_RESULT: begin
            if (out_free) begin
               out_v_in = 1'b1;
               kind_in = KIND_DONE; seg_in = '0; off_in = '0; dat_in = '0;
               widx_in = cur_ff.ra;
               if (halted_ff) kind_in = KIND_HALT;
               else if (cur_ff.is_resp) begin
                  if (!waiting_ff) kind_in = KIND_ERR;
                  else begin
                     waiting_in = 1'b0;
                     wval_in = cur_ff.resp;
                     widx_in = pend_ff;
                  end
               end else if (waiting_ff) kind_in = KIND_ERR;
               else if (cur_ff.op == OP_DIV && rc_v == '0) kind_in = KIND_ERR;
               else begin
                  pc_in = pc_ff + 32'd1;
                  case (cur_ff.op)
                     OP_CMOV: begin
                        wval_in = rb_v;
                        if (rc_v == '0) wval_in = ra_v;
                     end
                     OP_LOAD: begin
                        kind_in = KIND_LOAD; seg_in = rb_v; off_in = rc_v;
                        waiting_in = 1'b1; pend_in = cur_ff.ra;
                     end
                     OP_STORE: begin
                        kind_in = KIND_STORE; seg_in = ra_v; off_in = rb_v; dat_in = rc_v;
                     end
                     OP_ADD:  wval_in = rb_v + rc_v;
                     OP_MUL:  prod_in = rb_v * rc_v;
                     OP_DIV:  div_start = 1'b1;
                     OP_NAND: wval_in = ~(rb_v & rc_v);
                     OP_HALT: begin
                        kind_in = KIND_HALT; halted_in = 1'b1;
                     end
                     OP_MAP: begin
                        kind_in = KIND_MAP; off_in = rc_v;
                        waiting_in = 1'b1; pend_in = cur_ff.rb;
                     end
                     OP_UNMAP: begin
                        kind_in = KIND_UNMAP; seg_in = rc_v;
                     end
                     OP_OUT: begin
                        kind_in = KIND_OUT; dat_in = rc_v;
                     end
                     OP_IN: begin
                        kind_in = KIND_INREQ; waiting_in = 1'b1; pend_in = cur_ff.rc;
                     end
                     OP_PROG: begin
                        kind_in = KIND_PROG; seg_in = rb_v; off_in = rc_v; pc_in = rc_v;
                     end
                     OP_LV: begin
                        wval_in = {7'd0, cur_ff.imm};
                        widx_in = cur_ff.lv_a;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

   // a response write goes straight in; writes of register ops wait in EX_WRITE
   logic resp_wr;
   assign resp_wr = (st_ff == EX_RESULT) && out_free && !halted_ff && cur_ff.is_resp
                    && waiting_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= EX_IDLE;
         pc_ff <= '0;
         waiting_ff <= 1'b0;
         halted_ff <= 1'b0;
         pend_ff <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         pc_ff <= pc_in;
         waiting_ff <= waiting_in;
         halted_ff <= halted_in;
         pend_ff <= pend_in;
         out_v_ff <= out_v_in;
         if (resp_wr) regs_ff[pend_ff] <= cur_ff.resp;
         else if (st_ff == EX_WRITE) regs_ff[widx_ff] <= wval_ff;
      end
      cur_ff <= cur_in;
      prod_ff <= prod_in; wval_ff <= wval_in; widx_ff <= widx_in;
      kind_ff <= kind_in; seg_ff <= seg_in; off_ff <= off_in; dat_ff <= dat_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = kind_ff;
   assign rsp_segment_id = seg_ff;
   assign rsp_offset_or_size = off_ff;
   assign rsp_data_value = dat_ff;
   assign rsp_next_pc = pc_ff;

`include "um32_instruction_executor_top_macros.svh"
   `UM_ASSERT_NXT(a_halt_sticky, clock, reset, halted_ff, halted_ff, "halt flag cleared")
   `UM_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, st_ff == EX_IDLE, "pop outside idle")
   `UM_ASSERT_NXT(a_out_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind), "stalled result changed")
endmodule

// ===== src/um32_instruction_executor_top.sv =====
// Top level of the UM32 instruction executor.
// Usage:
//  req_ channel: one item per transfer; req_action 0 carries an instruction in
//   req_instr_word, 1 carries a response word in req_response_data for the
//   pending register after a load, map or input request.
//  rsp_ channel: exactly one result per item, in order: kind, segment, offset
//   or size, data and the program counter after the item.
//  Path: each item passes through the queue, EX_RESULT and the output register
//   to rsp_valid; the result leaves before a register write finishes.
//  Flow: the back end pops a new item only in EX_IDLE, after the last one leaves
//   EX_RESULT and, for register ops, EX_WRITE; multiply also passes EX_MUL and
//   divide waits in EX_DIV (the 32-step radix-2 divider sets the worst case).
//  A two-entry queue between front and back lets the input take transfers
//  while the back end works or a result waits.
//  Reset clears registers, pc, waiting and halt state and empties the queue.
//  When rsp_stall is high the result holds, the back end stops, the queue
//  fills and req_stall rises.
module um32_instruction_executor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_response_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [31:0] rsp_segment_id,
   output logic [31:0] rsp_offset_or_size,
   output logic [31:0] rsp_data_value,
   output logic [31:0] rsp_next_pc
);
   import um32_pkg::*;

   logic q_valid, q_pop;
   item_type q_item;

   // front: decode and queue
   um32_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_instr_word(req_instr_word),
      .req_response_data(req_response_data), .q_valid(q_valid), .q_pop(q_pop),
      .q_item(q_item)
   );

   // back: execute and present results
   um32_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_segment_id(rsp_segment_id), .rsp_offset_or_size(rsp_offset_or_size),
      .rsp_data_value(rsp_data_value), .rsp_next_pc(rsp_next_pc)
   );
endmodule
